>>> rtl/prime_field_mul_normalize_defines.svh
// assertion macros used by the top-level rtl file
`ifndef PRIME_FIELD_MUL_NORMALIZE_DEFINES_SVH
`define PRIME_FIELD_MUL_NORMALIZE_DEFINES_SVH

// same-cycle implication
`define PFMN_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFMN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pfmn_pkg.sv
// types, constants and helper functions for the field multiply and normalize block
package pfmn_pkg;

    localparam int LATENCY = 18;

    localparam logic [51:0] MASK52    = 52'hFFFFFFFFFFFFF;
    localparam logic [47:0] MASK48    = 48'hFFFFFFFFFFFF;
    localparam logic [51:0] PRIME_LOW = 52'hFFFFEFFFFFC2F;
    // 2^256 mod p = 2^32 + 0x3d1, 2^260 mod p = 2^36 + 0x3d10
    localparam logic [9:0]  FOLD256_LOW = 10'h3D1;
    localparam logic [13:0] FOLD260_LOW = 14'h3D10;

    localparam logic ACT_MUL  = 1'b0;
    localparam logic ACT_NORM = 1'b1;

    typedef struct packed {
        logic        action;
        logic [55:0] a_limb0;
        logic [55:0] a_limb1;
        logic [55:0] a_limb2;
        logic [55:0] a_limb3;
        logic [51:0] a_limb4;
        logic [55:0] b_limb0;
        logic [55:0] b_limb1;
        logic [55:0] b_limb2;
        logic [55:0] b_limb3;
        logic [51:0] b_limb4;
    } in_t;

    typedef struct packed {
        logic [51:0] r_limb0;
        logic [52:0] r_limb1;
        logic [51:0] r_limb2;
        logic [51:0] r_limb3;
        logic [47:0] r_limb4;
    } out_t;

    typedef logic [4:0][55:0] limbs56_t;

    typedef struct packed {
        limbs56_t   t;
        logic [8:0] top;
    } cp_res_t;

    // top * (2^256 mod p)
    function automatic logic [41:0] fold256(logic [8:0] top);
        fold256 = (42'(top) << 32) + 42'(top) * 42'(FOLD256_LOW);
    endfunction

    // one carry pass over five limbs, returns the carry above bit 256
    function automatic cp_res_t carry_pass(limbs56_t t, logic [41:0] add0);
        logic [56:0] c;
        cp_res_t     r;
        c = 57'(t[0]) + 57'(add0);
        r.t[0] = 56'(c[51:0]);
        c = 57'(c[56:52]) + 57'(t[1]);
        r.t[1] = 56'(c[51:0]);
        c = 57'(c[56:52]) + 57'(t[2]);
        r.t[2] = 56'(c[51:0]);
        c = 57'(c[56:52]) + 57'(t[3]);
        r.t[3] = 56'(c[51:0]);
        c = 57'(c[56:52]) + 57'(t[4]);
        r.t[4] = 56'(c[47:0]);
        r.top = c[56:48];
        return r;
    endfunction

endpackage

>>> rtl/prime_field_mul_normalize.sv
// top level of the field multiply and normalize block mod 2^256 - 2^32 - 977
//
//  channel | direction | payload          | handshake
//  op      | in        | pfmn_pkg::in_t   | op_valid / op_ready
//  res     | out       | pfmn_pkg::out_t  | res_valid / res_ready
//
// one transfer per cycle in, one result per cycle out while res is not stalled
// latency is set by the multiply path: products, columns, nine carry steps, six fold steps
// rst_n clears only the valid bits; payload registers are not reset
// a stall at res freezes the whole pipeline, op_ready drops only while a result waits
// and the last stage is full
`include "prime_field_mul_normalize_defines.svh"

module prime_field_mul_normalize (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  pfmn_pkg::in_t  op,
    output logic           res_valid,
    input  logic           res_ready,
    output pfmn_pkg::out_t res
);

    localparam int LAT = pfmn_pkg::LATENCY;

    logic           advance;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] act_reg;
    pfmn_pkg::out_t mul_res;
    pfmn_pkg::out_t norm_res;

    assign advance  = !vld_reg[LAT-1] || res_ready;
    assign op_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[LAT-2:0], op_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act_reg <= {act_reg[LAT-2:0], op.action};
        end
    end

    pfmn_mul_pipe u_mul (
        .clk (clk),
        .en  (advance),
        .op  (op),
        .res (mul_res)
    );

    pfmn_norm_pipe u_norm (
        .clk (clk),
        .en  (advance),
        .op  (op),
        .res (norm_res)
    );

    assign res_valid = vld_reg[LAT-1];
    assign res       = (act_reg[LAT-1] == pfmn_pkg::ACT_NORM) ? norm_res : mul_res;

    `PFMN_ASSERT_NEXT(a_enter, clk, rst_n, op_valid && op_ready, vld_reg[0], "accepted transfer did not enter the pipeline")
    `PFMN_ASSERT_NEXT(a_hold, clk, rst_n, !advance, $stable(vld_reg), "pipeline valid bits moved during a stall")
    `PFMN_ASSERT(a_norm_r1, clk, rst_n, res_valid && (act_reg[LAT-1] == pfmn_pkg::ACT_NORM), res.r_limb1[52] == 1'b0, "normalized limb one exceeds 52 bits")

endmodule

>>> rtl/pfmn_mul_pipe.sv
// multiply pipeline: partial products, columns, carry ripple and fold back mod p
module pfmn_mul_pipe (
    input  logic          clk,
    input  logic          en,
    input  pfmn_pkg::in_t op,
    output pfmn_pkg::out_t res
);

    logic [55:0]  a_w [0:4];
    logic [55:0]  b_w [0:4];
    logic [55:0]  pp_reg [0:24][0:3];
    logic [111:0] prod_reg [0:24];
    logic [114:0] col_next [0:8];
    logic [114:0] col_reg [0:8][0:8];
    logic [51:0]  t_reg [1:9][0:8];
    logic [63:0]  cy_reg [1:9];
    logic [51:0]  ft_reg [0:3][0:8];
    logic [63:0]  ft9_reg [0:3];
    logic [51:0]  fr_reg [0:4][0:4];
    logic [57:0]  fc_reg [0:4];
    pfmn_pkg::out_t res_reg;
    pfmn_pkg::out_t res_next;

    assign a_w[0] = op.a_limb0;
    assign a_w[1] = op.a_limb1;
    assign a_w[2] = op.a_limb2;
    assign a_w[3] = op.a_limb3;
    assign a_w[4] = 56'(op.a_limb4);
    assign b_w[0] = op.b_limb0;
    assign b_w[1] = op.b_limb1;
    assign b_w[2] = op.b_limb2;
    assign b_w[3] = op.b_limb3;
    assign b_w[4] = 56'(op.b_limb4);

    // 28 x 28 partial products of every limb pair
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 5; i++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    pp_reg[i*5+j][0] <= 56'(a_w[i][27:0]) * 56'(b_w[j][27:0]);
                    pp_reg[i*5+j][1] <= 56'(a_w[i][27:0]) * 56'(b_w[j][55:28]);
                    pp_reg[i*5+j][2] <= 56'(a_w[i][55:28]) * 56'(b_w[j][27:0]);
                    pp_reg[i*5+j][3] <= 56'(a_w[i][55:28]) * 56'(b_w[j][55:28]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < 25; n++)
            begin
                prod_reg[n] <= 112'(pp_reg[n][0]) + (112'(pp_reg[n][1]) << 28)
                             + (112'(pp_reg[n][2]) << 28) + (112'(pp_reg[n][3]) << 56);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            col_next[k] = '0;
            for (int i = 0; i < 5; i++)
            begin
                if ((k - i >= 0) && (k - i < 5))
                begin
                    col_next[k] = col_next[k] + 115'(prod_reg[i*5+k-i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg[0] <= col_next;
        end
    end

    // one column of carry propagation per stage
    for (genvar s = 1; s <= 9; s++)
    begin : g_rip
        logic [63:0]  cin;
        logic [115:0] sum;
        logic [51:0]  t_prev [0:8];
        if (s == 1)
        begin : g_first
            assign cin    = '0;
            assign t_prev = '{default: '0};
        end
        else
        begin : g_rest
            assign cin    = cy_reg[s-1];
            assign t_prev = t_reg[s-1];
        end
        assign sum = 116'(col_reg[s-1][s-1]) + 116'(cin);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cy_reg[s] <= sum[115:52];
                for (int k = 0; k < 9; k++)
                begin
                    if (k == s - 1)
                    begin
                        t_reg[s][k] <= sum[51:0];
                    end
                    else
                    begin
                        t_reg[s][k] <= t_prev[k];
                    end
                end
            end
        end

        if (s < 9)
        begin : g_cols
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    col_reg[s] <= col_reg[s-1];
                end
            end
        end
    end

    // fold limb f+5 onto limb f with 2^260 mod p
    for (genvar f = 0; f < 5; f++)
    begin : g_fold
        logic [51:0]  tin [0:8];
        logic [63:0]  t9in;
        logic [57:0]  cin;
        logic [63:0]  hv;
        logic [105:0] acc;
        logic [51:0]  fr_prev [0:4];
        if (f == 0)
        begin : g_first
            assign tin     = t_reg[9];
            assign t9in    = cy_reg[9];
            assign cin     = '0;
            assign fr_prev = '{default: '0};
        end
        else
        begin : g_rest
            assign tin     = ft_reg[f-1];
            assign t9in    = ft9_reg[f-1];
            assign cin     = fc_reg[f-1];
            assign fr_prev = fr_reg[f-1];
        end
        if (f == 4)
        begin : g_top
            assign hv = t9in;
        end
        else
        begin : g_mid
            assign hv = 64'(tin[f+5]);
        end
        assign acc = 106'(cin) + 106'(tin[f]) + (106'(hv) << 36)
                   + 106'(hv) * 106'(pfmn_pkg::FOLD260_LOW);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 5; k++)
                begin
                    if (k != f)
                    begin
                        fr_reg[f][k] <= fr_prev[k];
                    end
                end
                if (f == 4)
                begin
                    fr_reg[f][f] <= 52'(acc[47:0]);
                    fc_reg[f]    <= acc[105:48];
                end
                else
                begin
                    fr_reg[f][f] <= acc[51:0];
                    fc_reg[f]    <= 58'(acc[105:52]);
                end
            end
        end

        if (f < 4)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ft_reg[f]  <= tin;
                    ft9_reg[f] <= t9in;
                end
            end
        end
    end

    // top carry above bit 256 folds into limb zero, its carry lands in limb one
    always_comb
    begin
        logic [90:0] c;
        c = 91'(fr_reg[4][0]) + (91'(fc_reg[4]) << 32)
          + 91'(fc_reg[4]) * 91'(pfmn_pkg::FOLD256_LOW);
        res_next.r_limb0 = c[51:0];
        res_next.r_limb1 = 53'(fr_reg[4][1]) + 53'(c[90:52]);
        res_next.r_limb2 = fr_reg[4][2];
        res_next.r_limb3 = fr_reg[4][3];
        res_next.r_limb4 = fr_reg[4][4][47:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/pfmn_norm_pipe.sv
// normalize pipeline: three carry passes, final subtract of p, delay to match multiply
module pfmn_norm_pipe (
    input  logic          clk,
    input  logic          en,
    input  pfmn_pkg::in_t op,
    output pfmn_pkg::out_t res
);

    localparam int DELAY = pfmn_pkg::LATENCY - 4;

    pfmn_pkg::limbs56_t a_w;
    pfmn_pkg::cp_res_t  p1_reg;
    pfmn_pkg::cp_res_t  p2_reg;
    pfmn_pkg::cp_res_t  p3_reg;
    pfmn_pkg::out_t     sub_next;
    pfmn_pkg::out_t     dl_reg [0:DELAY];

    assign a_w[0] = op.a_limb0;
    assign a_w[1] = op.a_limb1;
    assign a_w[2] = op.a_limb2;
    assign a_w[3] = op.a_limb3;
    assign a_w[4] = 56'(op.a_limb4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= pfmn_pkg::carry_pass(a_w, '0);
            p2_reg <= pfmn_pkg::carry_pass(p1_reg.t, pfmn_pkg::fold256(p1_reg.top));
            p3_reg <= pfmn_pkg::carry_pass(p2_reg.t, pfmn_pkg::fold256(p2_reg.top));
        end
    end

    // value in [p, 2^256) subtracts p once
    always_comb
    begin
        logic [41:0]        add0;
        pfmn_pkg::limbs56_t t;
        add0 = pfmn_pkg::fold256(p3_reg.top);
        t    = p3_reg.t;
        t[0] = t[0] + 56'(add0);
        if ((t[4] == 56'(pfmn_pkg::MASK48)) && (t[3] == 56'(pfmn_pkg::MASK52))
            && (t[2] == 56'(pfmn_pkg::MASK52)) && (t[1] == 56'(pfmn_pkg::MASK52))
            && (t[0] >= 56'(pfmn_pkg::PRIME_LOW)))
        begin
            sub_next.r_limb0 = 52'(t[0] - 56'(pfmn_pkg::PRIME_LOW));
            sub_next.r_limb1 = '0;
            sub_next.r_limb2 = '0;
            sub_next.r_limb3 = '0;
            sub_next.r_limb4 = '0;
        end
        else
        begin
            sub_next.r_limb0 = t[0][51:0];
            sub_next.r_limb1 = 53'(t[1][51:0]);
            sub_next.r_limb2 = t[2][51:0];
            sub_next.r_limb3 = t[3][51:0];
            sub_next.r_limb4 = t[4][47:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= sub_next;
            for (int d = 1; d <= DELAY; d++)
            begin
                dl_reg[d] <= dl_reg[d-1];
            end
        end
    end

    assign res = dl_reg[DELAY];

endmodule

>>> bench/tb_prime_field_mul_normalize.sv
// testbench for the field multiply and normalize block mod 2^256 - 2^32 - 977
`timescale 1ns / 100ps

module tb_prime_field_mul_normalize;

    localparam int NUM_RANDOM  = 700;
    localparam int QUIET_TAIL  = 80;
    localparam int STALL_LIMIT = 4000;
    localparam logic [63:0] FOLD_HI = 64'h1000003D10;
    localparam logic [63:0] FOLD_LO = 64'h1000003D1;

    logic clk;
    logic rst_n;
    logic op_valid;
    logic op_ready;
    pfmn_pkg::in_t  op;
    logic res_valid;
    logic res_ready;
    pfmn_pkg::out_t res;

    pfmn_pkg::in_t  pending_ops[$];
    pfmn_pkg::out_t expected_res[$];
    int   err_count;
    int   idle_left;
    int   stall_left;
    int   quiet_cycles;
    logic stim_done;

    prime_field_mul_normalize u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // schoolbook product, fold of limbs five to nine, then a second fold above 2^256
    function automatic pfmn_pkg::out_t field_product(pfmn_pkg::in_t x);
        logic [63:0]  av[5];
        logic [63:0]  bv[5];
        logic [63:0]  col[10];
        logic [127:0] acc;
        logic [63:0]  lo0;
        logic [63:0]  lo1;
        pfmn_pkg::out_t r;
        av = '{x.a_limb0, x.a_limb1, x.a_limb2, x.a_limb3, x.a_limb4};
        bv = '{x.b_limb0, x.b_limb1, x.b_limb2, x.b_limb3, x.b_limb4};
        acc = '0;
        for (int k = 0; k < 9; k++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                if (k - i >= 0 && k - i < 5)
                    acc = acc + 128'(av[i]) * 128'(bv[k - i]);
            end
            col[k] = 64'(acc[51:0]);
            acc = acc >> 52;
        end
        col[9] = acc[63:0];
        acc = 128'(col[0]) + 128'(col[5]) * 128'(FOLD_HI);
        lo0 = 64'(acc[51:0]);
        acc = acc >> 52;
        acc = acc + 128'(col[1]) + 128'(col[6]) * 128'(FOLD_HI);
        lo1 = 64'(acc[51:0]);
        acc = acc >> 52;
        acc = acc + 128'(col[2]) + 128'(col[7]) * 128'(FOLD_HI);
        r.r_limb2 = acc[51:0];
        acc = acc >> 52;
        acc = acc + 128'(col[3]) + 128'(col[8]) * 128'(FOLD_HI);
        r.r_limb3 = acc[51:0];
        acc = acc >> 52;
        acc = acc + 128'(col[4]) + 128'(col[9]) * 128'(FOLD_HI);
        r.r_limb4 = acc[47:0];
        acc = acc >> 48;
        acc = 128'(lo0) + 128'(acc[63:0]) * 128'(FOLD_LO);
        r.r_limb0 = acc[51:0];
        acc = acc >> 52;
        r.r_limb1 = 53'(lo1 + acc[63:0]);
        return r;
    endfunction

    function automatic pfmn_pkg::out_t field_reduce(pfmn_pkg::in_t x);
        logic [63:0] t[5];
        logic [63:0] c;
        logic [63:0] carry_top;
        pfmn_pkg::out_t r;
        t = '{x.a_limb0, x.a_limb1, x.a_limb2, x.a_limb3, x.a_limb4};
        carry_top = 0;
        for (int pass = 0; pass < 3; pass++)
        begin
            c = t[0] + carry_top * FOLD_LO;
            for (int i = 0; i < 4; i++)
            begin
                t[i] = c & 64'(pfmn_pkg::MASK52);
                c = (c >> 52) + t[i + 1];
            end
            t[4] = c & 64'(pfmn_pkg::MASK48);
            carry_top = c >> 48;
        end
        // value in [p, 2^256): subtract p once
        if (t[4] == 64'(pfmn_pkg::MASK48) && t[3] == 64'(pfmn_pkg::MASK52)
            && t[2] == 64'(pfmn_pkg::MASK52) && t[1] == 64'(pfmn_pkg::MASK52)
            && t[0] >= 64'(pfmn_pkg::PRIME_LOW))
        begin
            t[0] = t[0] - 64'(pfmn_pkg::PRIME_LOW);
            t[1] = 0;
            t[2] = 0;
            t[3] = 0;
            t[4] = 0;
        end
        r.r_limb0 = t[0][51:0];
        r.r_limb1 = t[1][52:0];
        r.r_limb2 = t[2][51:0];
        r.r_limb3 = t[3][51:0];
        r.r_limb4 = t[4][47:0];
        return r;
    endfunction

    function automatic pfmn_pkg::in_t make_op(logic act, logic [55:0] a0, logic [55:0] a1,
                                    logic [55:0] a2, logic [55:0] a3, logic [51:0] a4,
                                    logic [55:0] b0, logic [55:0] b1, logic [55:0] b2,
                                    logic [55:0] b3, logic [51:0] b4);
        pfmn_pkg::in_t x;
        x = '{act, a0, a1, a2, a3, a4, b0, b1, b2, b3, b4};
        return x;
    endfunction

    function automatic logic [55:0] rand56();
        return 56'({$urandom, $urandom} >> 8);
    endfunction

    // limb value of magnitude up to eight
    function automatic logic [55:0] rand_mag(int unsigned top_bits);
        logic [55:0] v;
        v = rand56() >> (56 - top_bits);
        if ($urandom_range(0, 7) == 0)
            v = (56'(1) << top_bits) - 56'($urandom_range(1, 8));
        return v;
    endfunction

    // driver: accepted ops are predicted at the transfer edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid  <= 1'b0;
            op        <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (op_valid && op_ready)
            begin
                expected_res.push_back(op.action == pfmn_pkg::ACT_NORM ? field_reduce(op)
                                                                       : field_product(op));
            end
            if (!op_valid || op_ready)
            begin
                if (idle_left > 0)
                begin
                    op_valid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (pending_ops.size() > 0)
                begin
                    if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    begin
                        op_valid  <= 1'b0;
                        idle_left <= $urandom_range(0, 10);
                    end
                    else
                    begin
                        op_valid <= 1'b1;
                        op       <= pending_ops.pop_front();
                    end
                end
                else
                begin
                    op_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge clk or negedge rst_n)
    begin
        pfmn_pkg::out_t want;
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    $error("result with nothing expected: %h", res);
                    err_count++;
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (res.r_limb0 !== want.r_limb0)
                    begin
                        $error("r_limb0 expected %h got %h", want.r_limb0, res.r_limb0);
                        err_count++;
                    end
                    if (res.r_limb1 !== want.r_limb1)
                    begin
                        $error("r_limb1 expected %h got %h", want.r_limb1, res.r_limb1);
                        err_count++;
                    end
                    if (res.r_limb2 !== want.r_limb2)
                    begin
                        $error("r_limb2 expected %h got %h", want.r_limb2, res.r_limb2);
                        err_count++;
                    end
                    if (res.r_limb3 !== want.r_limb3)
                    begin
                        $error("r_limb3 expected %h got %h", want.r_limb3, res.r_limb3);
                        err_count++;
                    end
                    if (res.r_limb4 !== want.r_limb4)
                    begin
                        $error("r_limb4 expected %h got %h", want.r_limb4, res.r_limb4);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 10);
                res_ready  <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((op_valid && op_ready) || (res_valid && res_ready) || stim_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [55:0] x[5];
        logic [55:0] y[5];
        int          kind;
        err_count    = 0;
        quiet_cycles = 0;
        stim_done    = 1'b0;
        rst_n        = 1'b0;

        // normalize: zero, p, p - 1, p + 5, 2^256 - 1, all fields full (double overflow), magnitude eight
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, pfmn_pkg::PRIME_LOW,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK48, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, pfmn_pkg::PRIME_LOW - 1,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK48, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, pfmn_pkg::PRIME_LOW + 5,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK48, '1, '1, '1, '1, '1));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK48,
                                      0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, '1, '1, '1, '1, '1,
                                      0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_NORM, 56'h7FFFFFFFFFFFF8,
                                      56'h7FFFFFFFFFFFF8, 56'h7FFFFFFFFFFFF8,
                                      56'h7FFFFFFFFFFFF8, 52'h7FFFFFFFFFFF8,
                                      0, 0, 0, 0, 0));
        // multiply: zero, one, full fields, magnitude eight, p - 1 squared, 2^256 - 1 times one, 2^256 squared
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, 0, 0, 0, 0, 0,
                                      '1, '1, '1, '1, '1));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, 1, 0, 0, 0, 0, 56'h123456789ABCD,
                                      56'h42, 56'hFFFFFFFFFFFFF, 0, 52'hFFFFFFFFFFFF));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, '1, '1, '1, '1, '1,
                                      '1, '1, '1, '1, '1));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, 56'h7FFFFFFFFFFFF8,
                                      56'h7FFFFFFFFFFFF8, 56'h7FFFFFFFFFFFF8,
                                      56'h7FFFFFFFFFFFF8, 52'h7FFFFFFFFFFF8,
                                      56'h7FFFFFFFFFFFF8, 56'h7FFFFFFFFFFFF8,
                                      56'h7FFFFFFFFFFFF8, 56'h7FFFFFFFFFFFF8,
                                      52'h7FFFFFFFFFFF8));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, pfmn_pkg::PRIME_LOW - 1,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK48, pfmn_pkg::PRIME_LOW - 1,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK48));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, pfmn_pkg::MASK52, pfmn_pkg::MASK52,
                                      pfmn_pkg::MASK52, pfmn_pkg::MASK52, pfmn_pkg::MASK48,
                                      1, 0, 0, 0, 0));
        pending_ops.push_back(make_op(pfmn_pkg::ACT_MUL, 0, 0, 0, 0, 52'h1000000000000,
                                      0, 0, 0, 0, 52'h1000000000000));

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 5; i++)
            begin
                if (kind < 5)
                begin
                    x[i] = rand_mag(i == 4 ? 51 : 55);
                    y[i] = rand_mag(i == 4 ? 51 : 55);
                end
                else
                begin
                    x[i] = rand56();
                    y[i] = rand56();
                end
            end
            if (kind == 8)
            begin
                // close to p, from below or above
                x[0] = pfmn_pkg::PRIME_LOW - 8 + $urandom_range(0, 16);
                x[1] = pfmn_pkg::MASK52;
                x[2] = pfmn_pkg::MASK52;
                x[3] = pfmn_pkg::MASK52;
                x[4] = pfmn_pkg::MASK48;
            end
            if (kind == 9)
                y = x;
            pending_ops.push_back(make_op(kind == 8 ? pfmn_pkg::ACT_NORM
                                                    : logic'($urandom_range(0, 1)),
                                          x[0], x[1], x[2], x[3], x[4][51:0],
                                          y[0], y[1], y[2], y[3], y[4][51:0]));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        @(posedge clk iff (!op_valid || op_ready));
        @(posedge clk iff expected_res.size() == 0);
        stim_done = 1'b1;
        repeat (pfmn_pkg::LATENCY + 10) @(posedge clk);
        if (err_count == 0 && expected_res.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/pfmn_pkg.sv
rtl/pfmn_mul_pipe.sv
rtl/pfmn_norm_pipe.sv
rtl/prime_field_mul_normalize.sv
bench/tb_prime_field_mul_normalize.sv
